### rtl/hbe_pkg.sv
// Shared types, constants and helpers for the HTTP body extractor.
package hbe_pkg;

  localparam int unsigned LENGTH_BITS = 24;
  localparam int unsigned BODY_LEN_W  = 24;
  localparam int unsigned ACC_EXT_W   = LENGTH_BITS + 4;
  localparam int unsigned MP_W        = 5;

  localparam logic [MP_W-1:0] KEY_LEN   = MP_W'(14);
  localparam logic [MP_W-1:0] DIGITS_AT = MP_W'(16);

  localparam logic [1:0] LC_START = 2'd0;
  localparam logic [1:0] LC_CR    = 2'd1;
  localparam logic [1:0] LC_TEXT  = 2'd2;

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_BODY    = 3'd1,
    PH_DONE    = 3'd2,
    PH_MISSING = 3'd3,
    PH_TOOBIG  = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t                 phase;
    logic [MP_W-1:0]        match_pos;
    logic [1:0]             line_cnt;
    logic                   in_digits;
    logic [LENGTH_BITS-1:0] accum;
    logic                   found;
    logic [LENGTH_BITS-1:0] fwd;
  } hbe_state_t;

  localparam hbe_state_t STATE_RST = '{
    phase:     PH_HEADER,
    match_pos: '0,
    line_cnt:  LC_START,
    in_digits: 1'b0,
    accum:     '0,
    found:     1'b0,
    fwd:       '0
  };

  typedef struct packed {
    logic [7:0]            body_byte;
    logic                  body_valid;
    logic                  body_last;
    logic [2:0]            status;
    logic [BODY_LEN_W-1:0] body_length;
  } hbe_result_t;

  // "Content-Length"
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6f;
      4'd2:    c = 8'h6e;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6e;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2d;
      4'd8:    c = 8'h4c;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6e;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### rtl/hbe_if.sv
// Stream interfaces for the extractor's byte input and result output.
interface hbe_in_if;
  import hbe_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface hbe_out_if;
  import hbe_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [7:0]            body_byte;
  logic                  body_valid;
  logic                  body_last;
  logic [2:0]            status;
  logic [BODY_LEN_W-1:0] body_length;
  modport source (output valid, output body_byte, output body_valid, output body_last,
                  output status, output body_length, input ready);
  modport sink   (input valid, input body_byte, input body_valid, input body_last,
                  input status, input body_length, output ready);
endinterface

### rtl/hbe_step.sv
// Per-byte next-state and result logic of the extractor.
module hbe_step (
  input  hbe_pkg::hbe_state_t  st,
  input  logic [7:0]           b,
  output hbe_pkg::hbe_state_t  nxt,
  output hbe_pkg::hbe_result_t res
);
  import hbe_pkg::*;

  logic                   is_digit;
  logic                   overflow;
  logic [ACC_EXT_W-1:0]   acc_ext;
  logic [ACC_EXT_W-1:0]   next_len;
  logic [LENGTH_BITS-1:0] fwd_inc;

  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign acc_ext  = ACC_EXT_W'(st.accum);
  assign next_len = (acc_ext << 3) + (acc_ext << 1) + ACC_EXT_W'(b[3:0]);
  assign fwd_inc  = st.fwd + LENGTH_BITS'(1);

  always_comb begin
    nxt      = st;
    overflow = 1'b0;
    res      = '0;
    unique case (st.phase)
      PH_HEADER: begin
        if (st.in_digits) begin
          if (is_digit) begin
            if (next_len[ACC_EXT_W-1:LENGTH_BITS] != '0) begin
              nxt.in_digits = 1'b0;
              nxt.phase     = PH_TOOBIG;
              overflow      = 1'b1;
            end else begin
              nxt.accum = next_len[LENGTH_BITS-1:0];
            end
          end else begin
            nxt.in_digits = 1'b0;
          end
        end
        if (!overflow) begin
          if (!st.found) begin
            if (st.match_pos < KEY_LEN && b == key_char(st.match_pos[3:0])) begin
              nxt.match_pos = st.match_pos + MP_W'(1);
            end else begin
              nxt.match_pos = (b == key_char(4'd0)) ? MP_W'(1) : MP_W'(0);
            end
            if (nxt.match_pos == KEY_LEN) nxt.found = 1'b1;
          end else if (st.match_pos >= KEY_LEN && st.match_pos < DIGITS_AT) begin
            nxt.match_pos = st.match_pos + MP_W'(1);
            if (nxt.match_pos == DIGITS_AT) nxt.in_digits = 1'b1;
          end
          if (b == CH_LF) begin
            nxt.in_digits = 1'b0;
            if (nxt.found && nxt.match_pos < DIGITS_AT) nxt.match_pos = DIGITS_AT;
            if (st.line_cnt == LC_CR) begin
              if (!nxt.found || nxt.accum == '0) nxt.phase = PH_MISSING;
              else                                nxt.phase = PH_BODY;
            end
            nxt.line_cnt = LC_START;
          end else if (st.line_cnt == LC_START && b == CH_CR) begin
            nxt.line_cnt = LC_CR;
          end else begin
            nxt.line_cnt = LC_TEXT;
          end
        end
      end
      PH_BODY: begin
        res.body_valid = 1'b1;
        res.body_byte  = b;
        nxt.fwd        = fwd_inc;
        if (fwd_inc >= st.accum) begin
          res.body_last = 1'b1;
          nxt.phase     = PH_DONE;
        end
      end
      default: begin
      end
    endcase
    res.status      = nxt.phase;
    res.body_length = BODY_LEN_W'(nxt.accum);
  end

endmodule

### rtl/http_body_extractor.sv
// Top level of the HTTP Content-Length body extractor.
// Takes response bytes and returns one result beat per byte, through the input register
// and then the result register. Throughput is one byte per clock while the output is not stalled;
// the path that sets the clock is the combinational step logic (key compare, times-ten-plus-digit
// update with overflow check, forwarded-count compare) between the input and result registers.
// The input register can let a new byte in while a finished beat still waits in the result register.
// Covers header parsing and body forwarding; the error/finished states are sticky and hold until reset.
module http_body_extractor (
  input logic        clk,
  input logic        rst_n,
  hbe_in_if.sink     in_ch,
  hbe_out_if.source  out_ch
);
  import hbe_pkg::*;

  logic        v1_r;
  logic [7:0]  byte_r;
  hbe_state_t  state_r;
  hbe_state_t  state_nxt;
  hbe_result_t res_nxt;
  hbe_result_t out_r;
  logic        out_valid_r;
  logic        adv;
  logic        in_ready;

  hbe_step u_step (
    .st  (state_r),
    .b   (byte_r),
    .nxt (state_nxt),
    .res (res_nxt)
  );

  assign adv      = v1_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !v1_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_RST;
    end else begin
      if (in_ready) v1_r <= in_ch.valid;
      if (adv) state_r <= state_nxt;
      out_valid_r <= adv || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) byte_r <= in_ch.in_byte;
    if (adv) out_r <= res_nxt;
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.body_byte   = out_r.body_byte;
  assign out_ch.body_valid  = out_r.body_valid;
  assign out_ch.body_last   = out_r.body_last;
  assign out_ch.status      = out_r.status;
  assign out_ch.body_length = out_r.body_length;

endmodule

### rtl/hbe_checker.sv
// Port-level checks for the extractor, bound to the top level.
module hbe_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           body_valid,
  input logic                           body_last,
  input logic [2:0]                     status,
  input logic [hbe_pkg::BODY_LEN_W-1:0] body_length
);
  import hbe_pkg::*;

  logic                  seen_r;
  logic [2:0]            last_status_r;
  logic [BODY_LEN_W-1:0] last_len_r;
  logic                  beat;
  logic                  last_terminal;

  assign beat          = out_valid && out_ready;
  assign last_terminal = (last_status_r == PH_DONE) || (last_status_r == PH_MISSING)
                         || (last_status_r == PH_TOOBIG);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r        <= 1'b0;
      last_status_r <= PH_HEADER;
      last_len_r    <= '0;
    end else if (beat) begin
      seen_r        <= 1'b1;
      last_status_r <= status;
      last_len_r    <= body_length;
    end
  end

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && body_last |-> body_valid && status == PH_DONE)
    else $error("last beat without body data or finished status");

  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    beat && seen_r && last_terminal |-> status == last_status_r && !body_valid)
    else $error("terminal status left or body data after it");

  a_len_mono: assert property (@(posedge clk) disable iff (!rst_n)
    beat && seen_r |-> body_length >= last_len_r)
    else $error("body length went down");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(body_length))
    else $error("stalled result beat changed");

endmodule

bind http_body_extractor hbe_checker u_hbe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .body_valid  (out_ch.body_valid),
  .body_last   (out_ch.body_last),
  .status      (out_ch.status),
  .body_length (out_ch.body_length)
);

### tb/http_body_extractor_test.sv
// Self-checking testbench for http_body_extractor: one HTTP response, every result beat checked.
`timescale 1ns / 1ps

module http_body_extractor_test;
  import hbe_pkg::*;

  typedef enum int {
    HDR_GOOD,
    HDR_MISSING,
    HDR_ZERO,
    HDR_OVERFLOW,
    HDR_CUT
  } header_case_t;

  localparam logic [8*14-1:0] KEY_BITS = "Content-Length";
  localparam int HOLD_CYCLES = 60;

  logic clk;
  logic rst_n;

  hbe_in_if  in_if ();
  hbe_out_if out_if ();

  http_body_extractor DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  logic [7:0]  response_bytes[$];
  hbe_result_t extractor_results[$];
  int          total_bytes = 0;
  int          bytes_taken = 0;
  int          mismatches = 0;
  int          body_beats = 0;
  int          last_marks = 0;
  int          hold_left = 0;
  bit          hold_done = 0;

  // parser copy
  phase_t                 rx_phase = PH_HEADER;
  logic [MP_W-1:0]        key_pos = '0;
  logic [1:0]             line_state = LC_START;
  logic                   collecting = 1'b0;
  logic [LENGTH_BITS-1:0] len_acc = '0;
  logic                   key_seen = 1'b0;
  logic [LENGTH_BITS-1:0] fwd_count = '0;

  function automatic logic [7:0] keyword_byte(input int i);
    return KEY_BITS[8*(13-i) +: 8];
  endfunction

  function automatic hbe_result_t parse_byte(input logic [7:0] b);
    hbe_result_t r;
    logic [ACC_EXT_W-1:0] grown;
    bit too_big;
    r = '0;
    too_big = 1'b0;
    if (rx_phase == PH_HEADER) begin
      if (collecting) begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          grown = ACC_EXT_W'(len_acc) * ACC_EXT_W'(10) + ACC_EXT_W'(b - CH_ZERO);
          if ((grown >> LENGTH_BITS) != 0) begin
            collecting = 1'b0;
            rx_phase = PH_TOOBIG;
            too_big = 1'b1;
          end else begin
            len_acc = grown[LENGTH_BITS-1:0];
          end
        end else begin
          collecting = 1'b0;
        end
      end
      if (!too_big) begin
        if (!key_seen) begin
          if (key_pos < KEY_LEN && b == keyword_byte(int'(key_pos)))
            key_pos = key_pos + 1'b1;
          else
            key_pos = (b == keyword_byte(0)) ? MP_W'(1) : MP_W'(0);
          if (key_pos == KEY_LEN)
            key_seen = 1'b1;
        end else if (key_pos >= KEY_LEN && key_pos < DIGITS_AT) begin
          key_pos = key_pos + 1'b1;
          if (key_pos == DIGITS_AT)
            collecting = 1'b1;
        end
        if (b == CH_LF) begin
          collecting = 1'b0;
          if (key_seen && key_pos < DIGITS_AT)
            key_pos = DIGITS_AT;
          if (line_state == LC_CR)
            rx_phase = (!key_seen || len_acc == 0) ? PH_MISSING : PH_BODY;
          line_state = LC_START;
        end else if (line_state == LC_START && b == CH_CR) begin
          line_state = LC_CR;
        end else begin
          line_state = LC_TEXT;
        end
      end
    end else if (rx_phase == PH_BODY) begin
      r.body_valid = 1'b1;
      r.body_byte = b;
      fwd_count = fwd_count + 1'b1;
      if (fwd_count >= len_acc) begin
        r.body_last = 1'b1;
        rx_phase = PH_DONE;
      end
    end
    r.status = rx_phase;
    r.body_length = len_acc;
    return r;
  endfunction

  function automatic int idle_pct(input bit rx_side);
    if (bytes_taken * 3 < total_bytes)
      return rx_side ? 80 : 27;
    else if (bytes_taken * 3 < 2 * total_bytes)
      return rx_side ? 27 : 80;
    return 0;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      response_bytes.push_back(s[i]);
  endtask

  task automatic end_line(input bit lf_only);
    if (!lf_only)
      response_bytes.push_back(CH_CR);
    response_bytes.push_back(CH_LF);
  endtask

  // random header line, sometimes a bare LF line before it or a keyword prefix inside
  task automatic push_noise_line();
    int len;
    int cut;
    logic [7:0] c;
    len = $urandom_range(1, 30);
    cut = 0;
    if ($urandom_range(0, 7) == 0)
      response_bytes.push_back(CH_LF);
    if ($urandom_range(0, 3) == 0)
      cut = $urandom_range(1, 13);
    for (int i = 0; i < cut; i++)
      response_bytes.push_back(keyword_byte(i));
    for (int i = 0; i < len; i++) begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_LF || (i == 0 && cut == 0 && c == CH_CR))
        c = 8'h20;
      response_bytes.push_back(c);
    end
    end_line($urandom_range(0, 3) == 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.in_byte <= 8'h00;
    end else begin
      if (in_if.valid && in_if.ready) begin
        extractor_results.push_back(parse_byte(in_if.in_byte));
        bytes_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (response_bytes.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          in_if.valid <= 1'b1;
          in_if.in_byte <= response_bytes.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure, with one long hold-off early in the run
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (!hold_done && bytes_taken >= 40) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  // result checker
  always @(posedge clk) begin
    hbe_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (extractor_results.size() == 0) begin
        $error("result beat with no byte outstanding");
        mismatches++;
      end else begin
        want = extractor_results.pop_front();
        check_field("body_byte", 32'(want.body_byte), 32'(out_if.body_byte));
        check_field("body_valid", 32'(want.body_valid), 32'(out_if.body_valid));
        check_field("body_last", 32'(want.body_last), 32'(out_if.body_last));
        check_field("status", 32'(want.status), 32'(out_if.status));
        check_field("body_length", 32'(want.body_length), 32'(out_if.body_length));
        if (out_if.body_valid === 1'b1)
          body_beats++;
        if (out_if.body_last === 1'b1)
          last_marks++;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("timed out with %0d of %0d bytes taken", bytes_taken, total_bytes);
    $display("http_body_extractor test failed");
    $finish;
  end

  initial begin
    header_case_t hcase;
    int pick;
    int n_lines;
    int key_at;
    int body_len;
    in_if.valid = 1'b0;
    in_if.in_byte = 8'h00;
    out_if.ready = 1'b0;
    rst_n = 1'b0;

    // opening: byte extremes, lone CR, bare LF line, keyword one char short
    response_bytes = '{8'h00, 8'hff, CH_CR, 8'h80, CH_CR, CH_LF, CH_LF};
    push_text("Content-Lengt");
    end_line(1'b0);

    pick = $urandom_range(0, 7);
    hcase = (pick < 4) ? HDR_GOOD : header_case_t'(pick - 3);
    if (hcase == HDR_GOOD) begin
      repeat ($urandom_range(4, 8)) push_noise_line();
      body_len = $urandom_range(500, 900);
      push_text("Content-Length: ");
      if ($urandom_range(0, 1))
        push_text("00");
      push_text($sformatf("%0d", body_len));
      if ($urandom_range(0, 1))
        push_text(" ;9");
      end_line(1'b0);
      push_noise_line();
      push_text("Content-Length: 42");
      end_line(1'b0);
      repeat ($urandom_range(1, 3)) push_noise_line();
      end_line(1'b0);
      repeat (body_len) response_bytes.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(30, 80)) response_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      n_lines = $urandom_range(45, 60);
      key_at = (hcase == HDR_OVERFLOW) ? n_lines - 2 : $urandom_range(1, n_lines - 1);
      for (int i = 0; i < n_lines; i++) begin
        if (i == key_at) begin
          case (hcase)
            HDR_ZERO: begin
              push_text("Content-Length: 0");
              end_line(1'b0);
            end
            HDR_OVERFLOW: begin
              push_text("Content-Length: ");
              push_text($sformatf("%0d", $urandom_range(16777216, 99999999)));
              end_line(1'b0);
            end
            HDR_CUT: begin
              push_text($urandom_range(0, 1) ? "Content-Length:" : "Content-Length");
              end_line(1'b0);
              push_text("12345");
              end_line(1'b0);
            end
            default: ;
          endcase
        end
        push_noise_line();
      end
      end_line(1'b0);
      repeat (40) response_bytes.push_back(8'($urandom_range(0, 255)));
    end
    total_bytes = response_bytes.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken < total_bytes || extractor_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("header case %s: %0d response bytes, %0d body bytes, %0d last marks",
             hcase.name(), total_bytes, body_beats, last_marks);
    $display("final phase %0d, parsed length %0d, mismatches %0d",
             rx_phase, len_acc, mismatches);
    if (mismatches == 0) begin
      $display("http_body_extractor test passed");
    end else begin
      $display("http_body_extractor test failed");
    end
    $finish;
  end

endmodule

### http_body_extractor.f
rtl/hbe_pkg.sv
rtl/hbe_if.sv
rtl/hbe_step.sv
rtl/http_body_extractor.sv
rtl/hbe_checker.sv
tb/http_body_extractor_test.sv
